// File: src/s2rgb_pkg.sv
// ----------------------------------------------------------------------------
// s2rgb_pkg: shared definitions for the scalar to RGB colormap
// Map codes, fixed-point constants, reciprocals and saturation helpers.
// ----------------------------------------------------------------------------
package s2rgb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COLOR_BITS = 16;
    localparam int LEVEL_W    = 18;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int COLOR_MAX  = (1 << COLOR_BITS) - 1;
    localparam int NUM_MAPS   = 12;

    // register index on the configuration port
    localparam logic REG_MAP_SELECT = 1'b0;

    // square root unit: 17 bit steps, three per stage
    localparam int ROOT_W      = 2 * COLOR_BITS + 1;
    localparam int ROOT_STEPS  = 17;
    localparam int STEPS_PER   = 3;
    localparam int ROOT_STAGES = (ROOT_STEPS + STEPS_PER - 1) / STEPS_PER;

    // reciprocals: floor(x/d) = (x * RECIP) >> SHIFT over the value ranges used
    localparam logic [22:0] RECIP3     = 23'd5592406;
    localparam int          RECIP3_SH  = 24;
    localparam logic [21:0] RECIP9     = 22'd3728271;
    localparam int          RECIP9_SH  = 25;
    localparam logic [29:0] RECIP10K   = 30'd879609303;
    localparam int          RECIP10K_SH = 43;

    localparam logic [COLOR_BITS-1:0] SUMMER_BLUE = 16'd26214;

    typedef enum logic [3:0] {
        MAP_JET, MAP_HOT, MAP_COOL, MAP_GRAY, MAP_PINK, MAP_BONE,
        MAP_COPPER, MAP_AUTUMN, MAP_SPRING, MAP_WINTER, MAP_SUMMER, MAP_HSV
    } map_t;

    function automatic logic [COLOR_BITS-1:0] sat_color(input logic [33:0] x);
        if (x > 34'(COLOR_MAX)) begin
            return COLOR_BITS'(COLOR_MAX);
        end
        return x[COLOR_BITS-1:0];
    endfunction

    // floor(r * 2^15 / 9) for a remainder of a division by nine
    function automatic logic [14:0] frac_ninth(input logic [3:0] r);
        case (r)
            4'd0:    return 15'd0;
            4'd1:    return 15'd3640;
            4'd2:    return 15'd7281;
            4'd3:    return 15'd10922;
            4'd4:    return 15'd14563;
            4'd5:    return 15'd18204;
            4'd6:    return 15'd21845;
            4'd7:    return 15'd25486;
            4'd8:    return 15'd29127;
            default: return 15'd0;
        endcase
    endfunction

endpackage

// File: src/s2rgb_root.sv
// ----------------------------------------------------------------------------
// s2rgb_root: pipelined integer square root with round-half-up
// Bitwise restoring root, three steps per stage, result saturated to color.
// ----------------------------------------------------------------------------
module s2rgb_root (
    input  logic                                aclk,
    input  logic [s2rgb_pkg::ROOT_STAGES-1:0]   stage_en,
    input  logic [s2rgb_pkg::ROOT_W-1:0]        rad_in,
    output logic [s2rgb_pkg::COLOR_BITS-1:0]    root_out
);
    import s2rgb_pkg::*;

    logic [ROOT_W-1:0] rem_reg  [ROOT_STAGES];
    logic [ROOT_W-1:0] res_reg  [ROOT_STAGES];
    logic [ROOT_W-1:0] rem_next [ROOT_STAGES];
    logic [ROOT_W-1:0] res_next [ROOT_STAGES];

    always_comb begin
        logic [ROOT_W-1:0] rm;
        logic [ROOT_W-1:0] rs;
        logic [ROOT_W-1:0] bt;
        int k;
        for (int j = 0; j < ROOT_STAGES; j++) begin
            if (j == 0) begin
                rm = rad_in;
                rs = '0;
            end else begin
                rm = rem_reg[j-1];
                rs = res_reg[j-1];
            end
            for (int s = 0; s < STEPS_PER; s++) begin
                k = j * STEPS_PER + s;
                if (k < ROOT_STEPS) begin
                    bt = ROOT_W'(1) << (ROOT_W - 1 - 2 * k);
                    if (rm >= rs + bt) begin
                        rm = rm - (rs + bt);
                        rs = (rs >> 1) + bt;
                    end else begin
                        rs = rs >> 1;
                    end
                end
            end
            // remainder is t - s*s here: round up past the half
            if (j == ROOT_STAGES - 1 && rm > rs) begin
                rs = rs + ROOT_W'(1);
            end
            rem_next[j] = rm;
            res_next[j] = rs;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < ROOT_STAGES; j++) begin
            if (stage_en[j]) begin
                rem_reg[j] <= rem_next[j];
                res_reg[j] <= res_next[j];
            end
        end
    end

    assign root_out = sat_color(34'(res_reg[ROOT_STAGES-1]));

endmodule

// File: src/scalar_to_rgb_colormap.sv
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap: pseudocolor map of a Q1.16 level to RGB
// Twelve selectable maps, eleven-stage pipeline with stall bubble collapse.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the output is stalled; depth is set by the
// six-stage square root used by the pink map, which every item passes through.
// Stages with no valid item take new data even while the output is stalled.
// Reset (aresetn low, synchronous) clears all valid bits and map_select.
module scalar_to_rgb_colormap (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [s2rgb_pkg::LEVEL_W-1:0]   s_level,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [s2rgb_pkg::COLOR_BITS-1:0]       m_red,
    output logic [s2rgb_pkg::COLOR_BITS-1:0]       m_green,
    output logic [s2rgb_pkg::COLOR_BITS-1:0]       m_blue
);
    import s2rgb_pkg::*;

    localparam int NSTG    = 5 + ROOT_STAGES;
    localparam int ROOT0   = 4;
    localparam int OUT_IDX = NSTG - 1;

    typedef struct packed {
        logic        blk;
        map_t        sel;
        logic [16:0] lvl;
    } st0_t;

    typedef struct packed {
        logic                  blk;
        map_t                  sel;
        logic [2:0][15:0]      simple;
        logic [15:0]           cop_r;
        logic [28:0]           cop_g_num;
        logic [28:0]           cop_b_num;
        logic [2:0][17:0]      hot_half;
        logic [2:0][17:0]      bone_y;
        logic [2:0][20:0]      pink_num;
    } st1_t;

    typedef struct packed {
        logic                  blk;
        map_t                  sel;
        logic [2:0][15:0]      simple;
        logic [15:0]           cop_r;
        logic [15:0]           cop_g;
        logic [15:0]           cop_b;
        logic [2:0][16:0]      hot_q;
        logic [2:0][16:0]      bone_q;
        logic [2:0][17:0]      pink_q;
        logic [2:0][20:0]      pink_num;
    } st2_t;

    typedef struct packed {
        logic                  pink;
        logic [2:0][15:0]      rgb;
    } side_t;

    logic [3:0]            map_sel_reg;
    logic [NSTG-1:0]       vld_reg;
    logic [NSTG-1:0]       en;
    st0_t                  p0_reg, p0_next;
    st1_t                  p1_reg, p1_next;
    st2_t                  p2_reg, p2_next;
    side_t                 side_reg [ROOT_STAGES+1];
    side_t                 side_next;
    logic [2:0][ROOT_W-1:0] rad_reg, rad_next;
    logic [2:0][15:0]      root_val;
    logic [2:0][15:0]      out_reg, out_next;

    // ---------------- configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAP_SELECT) ? 32'(map_sel_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_sel_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAP_SELECT) begin
            map_sel_reg <= pwdata[3:0];
        end
    end

    // ---------------- stage enables: a stage loads when empty or draining
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[OUT_IDX];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage 0: capture level, range check, wrap selector
    always_comb begin
        p0_next.lvl = s_level[16:0];
        p0_next.blk = s_level[LEVEL_W-1] || (s_level[16:0] > 17'(ONE));
        p0_next.sel = map_t'((map_sel_reg >= 4'(NUM_MAPS)) ?
                             map_sel_reg - 4'(NUM_MAPS) : map_sel_reg);
    end

    // ---------------- stage 1: linear maps, hot parts, numerators
    always_comb begin
        logic [16:0]      l;
        logic [19:0]      l8;
        logic [20:0]      lw;
        logic [2:0][18:0] h;
        logic [15:0]      jr, jg, jb;
        logic [16:0]      hl;
        logic [19:0]      six_hl;
        logic [2:0]       seg;
        logic [15:0]      up, dn, hr, hg, hb;
        logic [15:0]      lin, inv;

        l  = p0_reg.lvl;
        l8 = {l, 3'b000};
        lw = 21'(l8);

        h = '0;
        if (l8 < 20'(3 * ONE)) begin
            h[0] = 19'({l, 4'b0000});
        end else if (l8 < 20'(6 * ONE)) begin
            h[0] = 19'(6 * ONE);
            h[1] = 19'({l, 4'b0000} - 21'(6 * ONE));
        end else begin
            h[0] = 19'(6 * ONE);
            h[1] = 19'(6 * ONE);
            h[2] = 19'(22'(l) * 22'(24) - 22'(18 * ONE));
        end

        jr = '0;
        jg = '0;
        jb = '0;
        if (l8 < 20'(ONE)) begin
            jb = sat_color(34'((21'(ONE) + lw + 21'd1) >> 1));
        end else if (l8 < 20'(3 * ONE)) begin
            jg = sat_color(34'((lw - 21'(ONE) + 21'd1) >> 1));
            jb = 16'(COLOR_MAX);
        end else if (l8 < 20'(5 * ONE)) begin
            jr = sat_color(34'((lw - 21'(3 * ONE) + 21'd1) >> 1));
            jg = 16'(COLOR_MAX);
            jb = sat_color(34'((21'(5 * ONE) - lw + 21'd1) >> 1));
        end else if (l8 < 20'(7 * ONE)) begin
            jr = 16'(COLOR_MAX);
            jg = sat_color(34'((21'(7 * ONE) - lw + 21'd1) >> 1));
        end else begin
            jr = sat_color(34'((21'(9 * ONE) - lw + 21'd1) >> 1));
        end

        // hue 1.0 wraps to red
        hl     = (l == 17'(ONE)) ? 17'd0 : l;
        six_hl = 20'(hl) * 20'd6;
        seg    = six_hl[18:16];
        up     = six_hl[15:0];
        dn     = sat_color(34'(18'(ONE) - 18'(six_hl[15:0])));
        case (seg)
            3'd0:    begin hr = 16'(COLOR_MAX); hg = up; hb = '0; end
            3'd1:    begin hr = dn; hg = 16'(COLOR_MAX); hb = '0; end
            3'd2:    begin hr = '0; hg = 16'(COLOR_MAX); hb = up; end
            3'd3:    begin hr = '0; hg = dn; hb = 16'(COLOR_MAX); end
            3'd4:    begin hr = up; hg = '0; hb = 16'(COLOR_MAX); end
            default: begin hr = 16'(COLOR_MAX); hg = '0; hb = dn; end
        endcase

        lin = sat_color(34'(l));
        inv = sat_color(34'(18'(ONE) - 18'(l)));

        p1_next.blk = p0_reg.blk;
        p1_next.sel = p0_reg.sel;
        case (p0_reg.sel)
            MAP_JET:    p1_next.simple = {jb, jg, jr};
            MAP_COOL:   p1_next.simple = {16'(COLOR_MAX), inv, lin};
            MAP_GRAY:   p1_next.simple = {lin, lin, lin};
            MAP_AUTUMN: p1_next.simple = {16'd0, lin, 16'(COLOR_MAX)};
            MAP_SPRING: p1_next.simple = {inv, lin, 16'(COLOR_MAX)};
            MAP_WINTER: p1_next.simple = {sat_color(34'((19'(2 * ONE) - 19'(l) + 19'd1) >> 1)),
                                          lin, 16'd0};
            MAP_SUMMER: p1_next.simple = {SUMMER_BLUE,
                                          sat_color(34'((19'(ONE) + 19'(l) + 19'd1) >> 1)),
                                          lin};
            MAP_HSV:    p1_next.simple = {hb, hg, hr};
            default:    p1_next.simple = '0;
        endcase

        p1_next.cop_r     = sat_color(34'((20'(l) * 20'd5 + 20'd2) >> 2));
        p1_next.cop_g_num = 29'(30'(l) * 30'd7812 + 30'd5000);
        p1_next.cop_b_num = 29'(30'(l) * 30'd4975 + 30'd5000);
        for (int i = 0; i < 3; i++) begin
            p1_next.hot_half[i] = 18'((20'(h[i]) + 20'd3) >> 1);
            // bone pairs red with the blue hot part and blue with red
            p1_next.bone_y[i]   = 18'((23'(l) * 23'd42 + 23'(h[2-i]) + 23'd24) >> 4);
            p1_next.pink_num[i] = 21'(22'(l) * 22'd12 + 22'(h[i]));
        end
    end

    // ---------------- stage 2: constant divisions by reciprocal multiply
    always_comb begin
        logic [40:0] ph;
        logic [40:0] pb;
        logic [42:0] pp;
        logic [58:0] pg;
        logic [58:0] pbl;

        p2_next.blk    = p1_reg.blk;
        p2_next.sel    = p1_reg.sel;
        p2_next.simple = p1_reg.simple;
        p2_next.cop_r  = p1_reg.cop_r;
        pg  = 59'(p1_reg.cop_g_num) * 59'(RECIP10K);
        pbl = 59'(p1_reg.cop_b_num) * 59'(RECIP10K);
        p2_next.cop_g = pg[RECIP10K_SH +: 16];
        p2_next.cop_b = pbl[RECIP10K_SH +: 16];
        for (int i = 0; i < 3; i++) begin
            ph = 41'(p1_reg.hot_half[i]) * 41'(RECIP3);
            pb = 41'(p1_reg.bone_y[i]) * 41'(RECIP3);
            pp = 43'(p1_reg.pink_num[i]) * 43'(RECIP9);
            p2_next.hot_q[i]    = ph[RECIP3_SH +: 17];
            p2_next.bone_q[i]   = pb[RECIP3_SH +: 17];
            p2_next.pink_q[i]   = pp[RECIP9_SH +: 18];
            p2_next.pink_num[i] = p1_reg.pink_num[i];
        end
    end

    // ---------------- stage 3: pick color, form root radicands
    always_comb begin
        logic [3:0] r1;
        for (int i = 0; i < 3; i++) begin
            r1 = 4'(p2_reg.pink_num[i] - 21'(p2_reg.pink_q[i]) * 21'd9);
            rad_next[i] = {p2_reg.pink_q[i], 15'd0} + ROOT_W'(frac_ninth(r1));
        end

        side_next.pink = 1'b0;
        case (p2_reg.sel)
            MAP_HOT: begin
                for (int i = 0; i < 3; i++) begin
                    side_next.rgb[i] = sat_color(34'(p2_reg.hot_q[i]));
                end
            end
            MAP_BONE: begin
                for (int i = 0; i < 3; i++) begin
                    side_next.rgb[i] = sat_color(34'(p2_reg.bone_q[i]));
                end
            end
            MAP_COPPER: side_next.rgb = {p2_reg.cop_b, p2_reg.cop_g, p2_reg.cop_r};
            MAP_PINK: begin
                side_next.rgb  = '0;
                side_next.pink = 1'b1;
            end
            default:    side_next.rgb = p2_reg.simple;
        endcase

        // out-of-range level: black
        if (p2_reg.blk) begin
            side_next.rgb  = '0;
            side_next.pink = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p0_reg <= p0_next;
        end
        if (en[1]) begin
            p1_reg <= p1_next;
        end
        if (en[2]) begin
            p2_reg <= p2_next;
        end
        if (en[3]) begin
            side_reg[0] <= side_next;
            rad_reg     <= rad_next;
        end
        for (int j = 1; j <= ROOT_STAGES; j++) begin
            if (en[ROOT0+j-1]) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
        if (en[OUT_IDX]) begin
            out_reg <= out_next;
        end
    end

    // ---------------- square roots for the pink map
    s2rgb_root u_root_r (
        .aclk     (aclk),
        .stage_en (en[ROOT0 +: ROOT_STAGES]),
        .rad_in   (rad_reg[0]),
        .root_out (root_val[0])
    );

    s2rgb_root u_root_g (
        .aclk     (aclk),
        .stage_en (en[ROOT0 +: ROOT_STAGES]),
        .rad_in   (rad_reg[1]),
        .root_out (root_val[1])
    );

    s2rgb_root u_root_b (
        .aclk     (aclk),
        .stage_en (en[ROOT0 +: ROOT_STAGES]),
        .rad_in   (rad_reg[2]),
        .root_out (root_val[2])
    );

    // ---------------- output register
    assign out_next = side_reg[ROOT_STAGES].pink ? root_val : side_reg[ROOT_STAGES].rgb;

    assign m_red   = out_reg[0];
    assign m_green = out_reg[1];
    assign m_blue  = out_reg[2];

    // ---------------- checks
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg))
        else $error("input blocked while the pipeline has an empty stage");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted item missing from the first stage");

endmodule
